[rtl/sha_pkg.sv]
// SHA-256 stream core package: commands, round constants, item types.
// Used by sha_front, sha_back and sha256_stream_hash_core.
`default_nettype none
package sha_pkg;

    localparam int CmdW = 2;
    localparam logic [CmdW-1:0] CMD_ABSORB     = 2'd0;
    localparam logic [CmdW-1:0] CMD_ABSORB_FIN = 2'd1;
    localparam logic [CmdW-1:0] CMD_FINISH     = 2'd2;

    localparam int QueueDepthDefault = 4;

    typedef struct packed {
        logic       fin;
        logic       has_byte;
        logic [7:0] data_byte;
    } op_t;

    localparam logic [255:0] INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[rtl/sha_front.sv]
// SHA-256 front end: accepts command items, drops undefined commands,
// queues byte and finish operations for the back end. Uses sha_pkg.
`default_nettype none
module sha_front
    import sha_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [CmdW-1:0] in_cmd,
    input  wire logic [7:0]      in_byte,
    output logic                 op_valid,
    input  wire logic            op_ready,
    output op_t                  op
);
    localparam int AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

    op_t           mem [QueueDepth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push, pop, keep;
    op_t           new_op;

    assign s_tready = (cnt_reg != (AW+1)'(QueueDepth));
    assign op_valid = (cnt_reg != '0);
    assign op       = mem[rd_reg];
    assign pop      = op_valid && op_ready;

    always_comb begin
        new_op.data_byte = in_byte;
        new_op.has_byte  = 1'b0;
        new_op.fin       = 1'b0;
        keep             = 1'b1;
        case (in_cmd)
            CMD_ABSORB:     new_op.has_byte = 1'b1;
            CMD_ABSORB_FIN: begin
                new_op.has_byte = 1'b1;
                new_op.fin      = 1'b1;
            end
            CMD_FINISH:     new_op.fin = 1'b1;
            default:        keep = 1'b0;
        endcase
    end

    assign push = s_tvalid && s_tready && keep;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (!push && pop) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= new_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= (wr_reg == AW'(QueueDepth - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (rd_reg == AW'(QueueDepth - 1)) ? '0 : rd_reg + 1'b1;
        end
    end
endmodule
`default_nettype wire

[rtl/sha_back.sv]
// SHA-256 back end: block buffer, padding, 64-round compression, digest
// output register. Uses sha_pkg.
`default_nettype none
module sha_back
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        op_valid,
    output logic             op_ready,
    input  op_t              op,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_word,
    output logic [2:0]       m_index,
    output logic             m_tlast
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    buf_mem [16];
    logic [5:0]     fill_reg;
    logic [63:0]    bits_reg;
    logic [255:0]   h_reg;
    logic [255:0]   v_reg;
    logic [511:0]   w_reg;
    logic [5:0]     rnd_reg;
    logic [3:0]     ld_reg;
    logic [5:0]     pad_reg;
    logic           fin_reg, second_reg, padded_reg;
    logic [2:0]     oidx_reg;
    logic [4:0]     fill_lane, pad_lane;

    // round datapath
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, wn, w15, w2, w0;
    always_comb begin
        a = v_reg[31:0];    b = v_reg[63:32];   c = v_reg[95:64];   d = v_reg[127:96];
        e = v_reg[159:128]; f = v_reg[191:160]; g = v_reg[223:192]; h = v_reg[255:224];
        w0  = w_reg[31:0];
        w15 = w_reg[63:32];
        w2  = w_reg[479:448];
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + round_k(rnd_reg) + w0;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        wn = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w_reg[319:288]
             + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w0;
    end

    assign op_ready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_word   = h_reg[32*oidx_reg +: 32];
    assign m_index  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'd7);

    logic [63:0] len_bits;
    assign len_bits = bits_reg + {55'd0, fill_reg, 3'd0};

    assign fill_lane = {~fill_reg[1:0], 3'b000};
    assign pad_lane  = {~pad_reg[1:0], 3'b000};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (op_valid) begin
                if (op.has_byte && fill_reg == 6'd63) state_next = S_LOAD;
                else if (op.fin) state_next = S_PAD;
            end
            S_PAD:   if (pad_reg == 6'd63) state_next = S_LOAD;
            S_LOAD:  if (ld_reg == 4'd15) state_next = S_ROUND;
            S_ROUND: if (rnd_reg == 6'd63) state_next = S_ADD;
            S_ADD: begin
                if (!fin_reg) state_next = S_IDLE;
                else if (!padded_reg || (!second_reg && fill_reg >= 6'd56)) state_next = S_PAD;
                else state_next = S_OUT;
            end
            S_OUT: if (m_tready && oidx_reg == 3'd7) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // padding byte written at pad_reg
    logic [7:0] pad_byte;
    always_comb begin
        if (!second_reg && pad_reg == fill_reg) pad_byte = 8'h80;
        else if (!second_reg && pad_reg < fill_reg)
            pad_byte = buf_mem[pad_reg[5:2]][pad_lane +: 8];
        else if (pad_reg >= 6'd56 && !(fill_reg >= 6'd56 && !second_reg))
            pad_byte = len_bits[8*(63-pad_reg) +: 8];
        else pad_byte = 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && op_valid && op.has_byte)
            buf_mem[fill_reg[5:2]][fill_lane +: 8] <= op.data_byte;
        else if (state_reg == S_PAD)
            buf_mem[pad_reg[5:2]][pad_lane +: 8] <= pad_byte;
    end

    logic [31:0] ld_comb;
    assign ld_comb = buf_mem[ld_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            h_reg      <= INIT_H;
            rnd_reg    <= '0;
            ld_reg     <= '0;
            pad_reg    <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            padded_reg <= 1'b0;
            oidx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: if (op_valid) begin
                    fin_reg    <= op.fin;
                    second_reg <= 1'b0;
                    padded_reg <= 1'b0;
                    pad_reg    <= '0;
                    ld_reg     <= '0;
                    if (op.has_byte) begin
                        fill_reg <= fill_reg + 1'b1;
                        if (fill_reg == 6'd63) bits_reg <= bits_reg + 64'd512;
                    end
                end
                S_PAD: begin
                    pad_reg    <= pad_reg + 1'b1;
                    ld_reg     <= '0;
                    padded_reg <= 1'b1;
                end
                S_LOAD: begin
                    w_reg  <= {ld_comb, w_reg[511:32]};
                    ld_reg <= ld_reg + 1'b1;
                    v_reg  <= h_reg;
                    rnd_reg <= '0;
                end
                S_ROUND: begin
                    v_reg   <= {g, f, e, d + t1, c, b, a, t1 + t2};
                    w_reg   <= {wn, w_reg[511:32]};
                    rnd_reg <= rnd_reg + 1'b1;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++)
                        h_reg[32*i +: 32] <= h_reg[32*i +: 32] + v_reg[32*i +: 32];
                    pad_reg <= '0;
                    oidx_reg <= '0;
                    if (fin_reg && padded_reg && !second_reg && fill_reg >= 6'd56)
                        second_reg <= 1'b1;
                    else second_reg <= 1'b0;
                end
                S_OUT: if (m_tready) begin
                    oidx_reg <= oidx_reg + 1'b1;
                    if (oidx_reg == 3'd7) begin
                        h_reg    <= INIT_H;
                        fill_reg <= '0;
                        bits_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/sha256_stream_hash_core.sv]
// SHA-256 byte stream hash core, top level.
// Joins sha_front and sha_back through an operation queue. Uses sha_pkg.
//
// channel | dir | handshake           | payload
// s_      | in  | s_tvalid / s_tready | tdata: cmd[1:0], data_byte[9:2]
// m_      | out | m_tvalid / m_tready | tdata: digest_word, word_index; tlast
//
// The back end takes bytes only in S_IDLE; every 64th byte starts a block load
// (S_LOAD) and the rounds (S_ROUND) of the single shared round unit, then an update (S_ADD).
// Finish adds a padding sweep (S_PAD) per padded block plus compression,
// then 8 output items. aresetn clears control state and resets the hash words to INIT_H.
// Input keeps flowing into the queue while the back end compresses, until the queue is full.
`default_nettype none
module sha256_stream_hash_core
    import sha_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // cmd[1:0], data_byte[9:2], zero[15:10]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // digest_word[31:0], word_index[34:32], zero
    output logic             m_tlast
);
    logic        op_valid, op_ready;
    op_t         op;
    logic [31:0] word;
    logic [2:0]  idx;

    sha_front #(.QueueDepth(QueueDepth)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_byte(s_tdata[9:2]),
        .op_valid(op_valid), .op_ready(op_ready), .op(op)
    );

    sha_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .op_valid(op_valid), .op_ready(op_ready), .op(op),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_word(word), .m_index(idx), .m_tlast(m_tlast)
    );

    assign m_tdata = {5'd0, idx, word};
endmodule
`default_nettype wire
